@@ rtl/pointer_gesture_classifier_macros.svh @@
// assertion helpers for the top-level rtl file
`ifndef POINTER_GESTURE_CLASSIFIER_MACROS_SVH
`define POINTER_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PGC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgc check failed");

// next-cycle implication, checked out of reset
`define PGC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgc check failed");

`endif

@@ rtl/pgc_pkg.sv @@
`default_nettype none

package pgc_pkg;

    localparam int unsigned POS_W    = 12;
    localparam int unsigned OFF_W    = POS_W + 1;
    localparam int unsigned TIMER_W  = 16;
    localparam int unsigned MS_W     = 10;
    localparam int unsigned KEY_W    = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [POS_W-1:0]   NEAR_LIMIT = 12'd10;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SWIPE_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_RATIO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LIMIT   = 3'd4;

    // key edge bit positions
    localparam int unsigned BIT_LEFT      = 0;
    localparam int unsigned BIT_RIGHT     = 1;
    localparam int unsigned BIT_ROTATE    = 2;
    localparam int unsigned BIT_START     = 3;
    localparam int unsigned BIT_PAUSE     = 4;
    localparam int unsigned BIT_HARD_DROP = 5;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_LEFT      = 3'd1,
        ACT_RIGHT     = 3'd2,
        ACT_ROTATE    = 3'd3,
        ACT_HARD_DROP = 3'd4,
        ACT_START     = 3'd5,
        ACT_PAUSE     = 3'd6
    } action_t;

    typedef struct packed {
        logic [11:0] swipe_limit;
        logic [11:0] click_radius;
        logic [11:0] drag_step;
        logic [7:0]  axis_ratio;
        logic [15:0] hold_limit;
    } cfg_t;

    // gesture tracking state; drag_offset is two's complement
    typedef struct packed {
        logic             pressed;
        logic             click_pending;
        logic             swipe_pending;
        logic             horizontal_drag;
        logic [POS_W-1:0] origin_x;
        logic [POS_W-1:0] origin_y;
        logic [OFF_W-1:0] drag_offset;
    } gesture_t;

    // magnitude of a signed offset in -4095..4095
    function automatic logic [POS_W-1:0] mag_off(input logic [OFF_W-1:0] v);
        logic [OFF_W-1:0] neg;
        begin
            neg = -v;
            mag_off = v[OFF_W-1] ? neg[POS_W-1:0] : v[POS_W-1:0];
        end
    endfunction

    // signed difference of two pixel positions
    function automatic logic [OFF_W-1:0] pos_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        begin
            pos_diff = {1'b0, a} - {1'b0, b};
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/pgc_track.sv @@
`default_nettype none

module pgc_track
    import pgc_pkg::*;
(
    input  cfg_t              cfg,
    input  gesture_t          cur,
    input  logic              button_down,
    input  logic [POS_W-1:0]  pos_x,
    input  logic [POS_W-1:0]  pos_y,
    output gesture_t          nxt
);

    logic [OFF_W-1:0] dx;
    logic [OFF_W-1:0] dy;
    logic [POS_W-1:0] ax;
    logic [POS_W-1:0] ay;
    logic [19:0]      y_scaled;
    logic [19:0]      x_scaled;
    logic             is_horizontal;
    logic [23:0]      ax_sq;
    logic [23:0]      ay_sq;
    logic [24:0]      dist_sq;
    logic [23:0]      radius_sq;
    logic             is_swipe;
    logic             is_click;

    assign dx = pos_diff(pos_x, cur.origin_x);
    assign dy = pos_diff(pos_y, cur.origin_y);
    assign ax = mag_off(dx);
    assign ay = mag_off(dy);

    // horizontal when |dy| * ratio / 16 < |dx|
    assign y_scaled      = 20'(ay) * 20'(cfg.axis_ratio);
    assign x_scaled      = {4'b0000, ax, 4'b0000};
    assign is_horizontal = y_scaled < x_scaled;

    assign ax_sq     = 24'(ax) * 24'(ax);
    assign ay_sq     = 24'(ay) * 24'(ay);
    assign dist_sq   = {1'b0, ax_sq} + {1'b0, ay_sq};
    assign radius_sq = 24'(cfg.click_radius) * 24'(cfg.click_radius);

    // downward far enough with sideways under half the limit
    assign is_swipe = ($signed({dy[OFF_W-1], dy}) > $signed({2'b00, cfg.swipe_limit}))
                   && ({ax, 1'b0} < {1'b0, cfg.swipe_limit});
    assign is_click = dist_sq < {1'b0, radius_sq};

    always_comb
    begin
        nxt = cur;
        if (button_down && !cur.pressed)
        begin
            nxt.pressed         = 1'b1;
            nxt.origin_x        = pos_x;
            nxt.origin_y        = pos_y;
            nxt.drag_offset     = '0;
            nxt.click_pending   = 1'b0;
            nxt.swipe_pending   = 1'b0;
            nxt.horizontal_drag = 1'b0;
        end
        else if (button_down && cur.pressed)
        begin
            nxt.drag_offset = dx;
            if ((ax > NEAR_LIMIT) || (ay > NEAR_LIMIT))
            begin
                nxt.horizontal_drag = is_horizontal;
            end
        end
        else if (!button_down && cur.pressed)
        begin
            if (is_swipe)
            begin
                nxt.swipe_pending = 1'b1;
            end
            else if (is_click)
            begin
                nxt.click_pending = 1'b1;
            end
            nxt.pressed         = 1'b0;
            nxt.drag_offset     = '0;
            nxt.horizontal_drag = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pgc_decide.sv @@
`default_nettype none

module pgc_decide
    import pgc_pkg::*;
(
    input  cfg_t                cfg,
    input  gesture_t            trk,
    input  logic [POS_W-1:0]    pos_x,
    input  logic [KEY_W-1:0]    key_edges,
    input  logic                soft_key_held,
    input  logic [MS_W-1:0]     frame_ms,
    input  logic [TIMER_W-1:0]  hold_timer,
    output gesture_t            nxt,
    output action_t             act,
    output logic [TIMER_W-1:0]  hold_timer_next,
    output logic                soft_drop
);

    logic [POS_W-1:0]   off_mag;
    logic               drag_move;
    logic               drag_right;
    logic [POS_W-1:0]   moved_origin;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_sat;

    assign off_mag    = mag_off(trk.drag_offset);
    assign drag_right = !trk.drag_offset[OFF_W-1] && (trk.drag_offset != '0);
    assign drag_move  = trk.pressed && trk.horizontal_drag && (off_mag >= cfg.drag_step);
    // never passes the pointer, so no wrap
    assign moved_origin = drag_right ? (trk.origin_x + cfg.drag_step)
                                     : (trk.origin_x - cfg.drag_step);

    always_comb
    begin
        nxt = trk;
        act = ACT_NONE;
        if (trk.swipe_pending)
        begin
            nxt.swipe_pending = 1'b0;
            act = ACT_HARD_DROP;
        end
        else if (trk.click_pending)
        begin
            nxt.click_pending = 1'b0;
            act = ACT_ROTATE;
        end
        else if (drag_move)
        begin
            nxt.origin_x    = moved_origin;
            nxt.drag_offset = pos_diff(pos_x, moved_origin);
            act = drag_right ? ACT_RIGHT : ACT_LEFT;
        end
        else if (key_edges[BIT_LEFT])
        begin
            act = ACT_LEFT;
        end
        else if (key_edges[BIT_RIGHT])
        begin
            act = ACT_RIGHT;
        end
        else if (key_edges[BIT_ROTATE])
        begin
            act = ACT_ROTATE;
        end
        else if (key_edges[BIT_START])
        begin
            act = ACT_START;
        end
        else if (key_edges[BIT_PAUSE])
        begin
            act = ACT_PAUSE;
        end
        else if (key_edges[BIT_HARD_DROP])
        begin
            act = ACT_HARD_DROP;
        end
    end

    // saturating hold timer, cleared while released
    assign timer_sum = {1'b0, hold_timer} + {{(TIMER_W + 1 - MS_W){1'b0}}, frame_ms};
    assign timer_sat = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];

    always_comb
    begin
        if (trk.pressed)
        begin
            hold_timer_next = timer_sat;
        end
        else
        begin
            hold_timer_next = '0;
        end
    end

    assign soft_drop = soft_key_held || (trk.pressed && (timer_sat > cfg.hold_limit));

endmodule

`default_nettype wire

@@ rtl/pointer_gesture_classifier.sv @@
// Pointer gesture classifier: one frame tick (button, position, key edges,
// soft-key hold, frame time) in, one result (action code, soft-drop flag) out.
// A tick is accepted on in_valid with in_stall low and captured in the input
// register; its result is then loaded into the output register, and while
// out_stall is low a new tick can be taken every cycle, so sustained
// throughput is one tick per clock. The output register holds a valid result
// while out_stall is high and the input register backs up behind it; in_stall
// only rises when both are full and the consumer stalls. Gesture state (press,
// origin, drag offset, pending flags, hold timer) is updated at the same edge
// that loads the result, so back-to-back ticks see each other's effect.
// Configuration writes (always ready) take effect on the next tick and should
// only be issued while no tick is in flight; indexes beyond the hold limit
// register are ignored.
`default_nettype none

`include "pointer_gesture_classifier_macros.svh"

module pointer_gesture_classifier
    import pgc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,

    // frame tick channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  button_down,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic [KEY_W-1:0]      key_edges,
    input  logic                  soft_key_held,
    input  logic [MS_W-1:0]       frame_ms,

    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            action,
    output logic                  soft_drop
);

    // configuration registers
    cfg_t cfg_reg;

    // input register
    logic               in_valid_reg;
    logic               button_down_reg;
    logic [POS_W-1:0]   pos_x_reg;
    logic [POS_W-1:0]   pos_y_reg;
    logic [KEY_W-1:0]   key_edges_reg;
    logic               soft_key_held_reg;
    logic [MS_W-1:0]    frame_ms_reg;

    // gesture state
    gesture_t           gesture_reg;
    gesture_t           gesture_tracked;
    gesture_t           gesture_next;
    logic [TIMER_W-1:0] hold_timer_reg;
    logic [TIMER_W-1:0] hold_timer_next;

    // result register
    logic               out_valid_reg;
    action_t            action_reg;
    action_t            action_next;
    logic               soft_drop_reg;
    logic               soft_drop_next;

    logic               advance;

    // the result slot is free or being drained this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign soft_drop = soft_drop_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swipe_limit  <= 12'd100;
            cfg_reg.click_radius <= 12'd20;
            cfg_reg.drag_step    <= 12'd40;
            cfg_reg.axis_ratio   <= 8'd24;
            cfg_reg.hold_limit   <= 16'd300;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SWIPE_LIMIT:  cfg_reg.swipe_limit  <= cfg_data[11:0];
                REG_CLICK_RADIUS: cfg_reg.click_radius <= cfg_data[11:0];
                REG_DRAG_STEP:    cfg_reg.drag_step    <= cfg_data[11:0];
                REG_AXIS_RATIO:   cfg_reg.axis_ratio   <= cfg_data[7:0];
                REG_HOLD_LIMIT:   cfg_reg.hold_limit   <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    // input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register: payload, loaded on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            button_down_reg   <= button_down;
            pos_x_reg         <= pos_x;
            pos_y_reg         <= pos_y;
            key_edges_reg     <= key_edges;
            soft_key_held_reg <= soft_key_held;
            frame_ms_reg      <= frame_ms;
        end
    end

    // press / drag / release update
    pgc_track u_track (
        .cfg         (cfg_reg),
        .cur         (gesture_reg),
        .button_down (button_down_reg),
        .pos_x       (pos_x_reg),
        .pos_y       (pos_y_reg),
        .nxt         (gesture_tracked)
    );

    // action priority and soft drop
    pgc_decide u_decide (
        .cfg             (cfg_reg),
        .trk             (gesture_tracked),
        .pos_x           (pos_x_reg),
        .key_edges       (key_edges_reg),
        .soft_key_held   (soft_key_held_reg),
        .frame_ms        (frame_ms_reg),
        .hold_timer      (hold_timer_reg),
        .nxt             (gesture_next),
        .act             (action_next),
        .hold_timer_next (hold_timer_next),
        .soft_drop       (soft_drop_next)
    );

    // state and result commit together when the tick moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gesture_reg    <= '0;
            hold_timer_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                gesture_reg    <= gesture_next;
                hold_timer_reg <= hold_timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            action_reg    <= action_next;
            soft_drop_reg <= soft_drop_next;
        end
    end

    // released pointer leaves no timer, drag offset or drag direction behind
    `PGC_ASSERT_NOW(a_release_clears_timer, !gesture_reg.pressed, hold_timer_reg == '0)
    `PGC_ASSERT_NOW(a_release_clears_drag, !gesture_reg.pressed,
        (gesture_reg.drag_offset == '0) && !gesture_reg.horizontal_drag)
    // a pending swipe or click is reported by the same tick that raised it
    `PGC_ASSERT_NEXT(a_pending_consumed, in_valid_reg && advance,
        !gesture_reg.click_pending && !gesture_reg.swipe_pending)
    // a tick leaving the input register always lands in the result register
    `PGC_ASSERT_NEXT(a_tick_reaches_output, in_valid_reg && advance, out_valid_reg)
    // backpressure only when both register stages are occupied
    `PGC_ASSERT_NOW(a_stall_only_when_full, in_stall, in_valid_reg && out_valid_reg)

endmodule

`default_nettype wire

@@ bench/pointer_gesture_classifier_tb.sv @@
`default_nettype none

module pointer_gesture_classifier_tb;
    import pgc_pkg::*;

    // one frame tick as driven onto the input channel
    typedef struct packed {
        logic              button;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [KEY_W-1:0]  keys;
        logic              soft_key;
        logic [MS_W-1:0]   ms;
    } frame_tick_t;

    // one result transaction
    typedef struct packed {
        action_t action;
        logic    soft_drop;
    } gesture_result_t;

    // directed stimulus row; typed rows carry a hand-written result
    typedef struct {
        frame_tick_t     tick;
        bit              typed;
        gesture_result_t want;
    } stim_row_t;

    localparam int PHASE_TICKS   = 200;
    localparam int PLAN_LEN      = 7;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    localparam int DRAIN_CYCLES  = 4;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 button_down;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [KEY_W-1:0]     key_edges;
    logic                 soft_key_held;
    logic [MS_W-1:0]      frame_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [2:0]           action;
    logic                 soft_drop;

    pointer_gesture_classifier u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .button_down   (button_down),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .key_edges     (key_edges),
        .soft_key_held (soft_key_held),
        .frame_ms      (frame_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .soft_drop     (soft_drop)
    );

    // 8 unit clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // gesture predictor: its own copy of the registers and tracking state
    // ------------------------------------------------------------------
    cfg_t                    gst_cfg;
    logic                    gst_pressed;
    logic                    gst_click_pend;
    logic                    gst_swipe_pend;
    logic                    gst_horiz;
    logic [POS_W-1:0]        gst_origin_x;
    logic [POS_W-1:0]        gst_origin_y;
    logic signed [OFF_W-1:0] gst_offset;
    logic [TIMER_W-1:0]      gst_hold_ms;

    gesture_result_t gesture_results_due[$];

    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int ticks_sent;
    int results_seen;
    int settings_seen;
    int soft_seen;
    int action_seen[8];
    int idle_cycles;

    function automatic void reset_gesture_model();
        gst_cfg.swipe_limit  = 12'd100;
        gst_cfg.click_radius = 12'd20;
        gst_cfg.drag_step    = 12'd40;
        gst_cfg.axis_ratio   = 8'd24;
        gst_cfg.hold_limit   = 16'd300;
        gst_pressed    = 1'b0;
        gst_click_pend = 1'b0;
        gst_swipe_pend = 1'b0;
        gst_horiz      = 1'b0;
        gst_origin_x   = '0;
        gst_origin_y   = '0;
        gst_offset     = '0;
        gst_hold_ms    = '0;
    endfunction

    // advances the gesture state by one tick and returns the result it causes
    function automatic gesture_result_t classify_tick(input frame_tick_t t);
        gesture_result_t r;
        int dx;
        int dy;
        int ax;
        int ay;
        int off;
        int step;
        int ox;
        logic [TIMER_W:0] sum;
        logic held;
        dx   = int'(t.x) - int'(gst_origin_x);
        dy   = int'(t.y) - int'(gst_origin_y);
        ax   = (dx < 0) ? -dx : dx;
        ay   = (dy < 0) ? -dy : dy;
        step = int'(gst_cfg.drag_step);
        held = 1'b0;

        // gesture update
        if (t.button && !gst_pressed)
        begin
            gst_pressed    = 1'b1;
            gst_origin_x   = t.x;
            gst_origin_y   = t.y;
            gst_offset     = '0;
            gst_click_pend = 1'b0;
            gst_swipe_pend = 1'b0;
            gst_horiz      = 1'b0;
        end
        else if (t.button && gst_pressed)
        begin
            gst_offset = OFF_W'(dx);
            if (ax > int'(NEAR_LIMIT) || ay > int'(NEAR_LIMIT))
                gst_horiz = (ay * int'(gst_cfg.axis_ratio)) < (ax * 16);
        end
        else if (!t.button && gst_pressed)
        begin
            if (dy > int'(gst_cfg.swipe_limit) && 2 * ax < int'(gst_cfg.swipe_limit))
                gst_swipe_pend = 1'b1;
            else if (ax * ax + ay * ay
                     < int'(gst_cfg.click_radius) * int'(gst_cfg.click_radius))
                gst_click_pend = 1'b1;
            gst_pressed = 1'b0;
            gst_offset  = '0;
            gst_horiz   = 1'b0;
        end

        // one action, fixed priority
        off = int'(gst_offset);
        if (gst_swipe_pend)
        begin
            gst_swipe_pend = 1'b0;
            r.action = ACT_HARD_DROP;
        end
        else if (gst_click_pend)
        begin
            gst_click_pend = 1'b0;
            r.action = ACT_ROTATE;
        end
        else if (gst_pressed && gst_horiz && ((off < 0) ? -off : off) >= step)
        begin
            ox = int'(gst_origin_x);
            if (off > 0)
            begin
                ox = ox + step;
                r.action = ACT_RIGHT;
            end
            else
            begin
                ox = ox - step;
                r.action = ACT_LEFT;
            end
            gst_origin_x = POS_W'(ox);
            gst_offset   = OFF_W'(int'(t.x) - ox);
        end
        else if (t.keys[BIT_LEFT])
            r.action = ACT_LEFT;
        else if (t.keys[BIT_RIGHT])
            r.action = ACT_RIGHT;
        else if (t.keys[BIT_ROTATE])
            r.action = ACT_ROTATE;
        else if (t.keys[BIT_START])
            r.action = ACT_START;
        else if (t.keys[BIT_PAUSE])
            r.action = ACT_PAUSE;
        else if (t.keys[BIT_HARD_DROP])
            r.action = ACT_HARD_DROP;
        else
            r.action = ACT_NONE;

        // hold timer saturates, cleared while released
        if (gst_pressed)
        begin
            sum = {1'b0, gst_hold_ms} + t.ms;
            gst_hold_ms = (sum > TIMER_MAX) ? TIMER_MAX : sum[TIMER_W-1:0];
            held = gst_hold_ms > gst_cfg.hold_limit;
        end
        else
        begin
            gst_hold_ms = '0;
        end
        r.soft_drop = t.soft_key || held;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [POS_W-1:0] clamp_px(input int v);
        if (v < 0)
            return '0;
        if (v > POS_MAX)
            return POS_W'(POS_MAX);
        return POS_W'(v);
    endfunction

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // tick with mostly quiet keys and short frame times
    function automatic frame_tick_t rand_tick(input logic btn, input int x, input int y);
        frame_tick_t t;
        t.button   = btn;
        t.x        = clamp_px(x);
        t.y        = clamp_px(y);
        t.keys     = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom_range(0, 63)) : '0;
        t.soft_key = ($urandom_range(0, 7) == 0);
        t.ms       = ($urandom_range(0, 7) == 0) ? MS_W'($urandom_range(0, 1000))
                                                 : MS_W'($urandom_range(0, 40));
        return t;
    endfunction

    stim_row_t stim_rows[$];

    function automatic void add_row(input int btn, input int x, input int y,
                                    input logic [KEY_W-1:0] keys, input int soft_hold,
                                    input int ms, input int typed,
                                    input action_t act, input int sd);
        stim_row_t row;
        row.tick.button   = (btn != 0);
        row.tick.x        = POS_W'(x);
        row.tick.y        = POS_W'(y);
        row.tick.keys     = keys;
        row.tick.soft_key = (soft_hold != 0);
        row.tick.ms       = MS_W'(ms);
        row.typed         = (typed != 0);
        row.want.action   = act;
        row.want.soft_drop = (sd != 0);
        stim_rows.push_back(row);
    endfunction

    // drive one tick transaction, record its result once the block takes it
    task automatic send_tick(input frame_tick_t t, input bit typed,
                             input gesture_result_t want);
        gesture_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        button_down   = t.button;
        pos_x         = t.x;
        pos_y         = t.y;
        key_edges     = t.keys;
        soft_key_held = t.soft_key;
        frame_ms      = t.ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = classify_tick(t);
        gesture_results_due.push_back(typed ? want : r);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic send_rand(input frame_tick_t t);
        gesture_result_t none;
        none = '0;
        send_tick(t, 1'b0, none);
    endtask

    // stop sending and let every outstanding result come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (gesture_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SWIPE_LIMIT:  gst_cfg.swipe_limit  = data[11:0];
            REG_CLICK_RADIUS: gst_cfg.click_radius = data[11:0];
            REG_DRAG_STEP:    gst_cfg.drag_step    = data[11:0];
            REG_AXIS_RATIO:   gst_cfg.axis_ratio   = data[7:0];
            REG_HOLD_LIMIT:   gst_cfg.hold_limit   = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_setting(input cfg_t c);
        logic [CFG_IDX_W-1:0] junk_idx;
        junk_idx = CFG_IDX_W'($urandom_range(int'(REG_HOLD_LIMIT) + 1,
                                             (1 << CFG_IDX_W) - 1));
        set_reg(REG_SWIPE_LIMIT, CFG_DAT_W'(c.swipe_limit));
        set_reg(REG_CLICK_RADIUS, CFG_DAT_W'(c.click_radius));
        set_reg(REG_DRAG_STEP, CFG_DAT_W'(c.drag_step));
        set_reg(REG_AXIS_RATIO, CFG_DAT_W'(c.axis_ratio));
        set_reg(REG_HOLD_LIMIT, c.hold_limit);
        // index past the last register must leave everything alone
        set_reg(junk_idx, CFG_DAT_W'($urandom_range(0, 65535)));
        settings_seen++;
    endtask

    // random part: mostly complete press/move/release gestures, some noise
    task automatic run_gestures(input int n);
        int target;
        int sel;
        int style;
        int len;
        int i;
        int x;
        int y;
        int rad;
        bit long_hold;
        frame_tick_t t;
        target = ticks_sent + n;
        while (ticks_sent < target)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                // raw noise, any value in every field but the frame time
                t.button   = 1'($urandom_range(0, 1));
                t.x        = POS_W'($urandom_range(0, POS_MAX));
                t.y        = POS_W'($urandom_range(0, POS_MAX));
                t.keys     = KEY_W'($urandom_range(0, 63));
                t.soft_key = 1'($urandom_range(0, 1));
                t.ms       = MS_W'($urandom_range(0, 1000));
                send_rand(t);
            end
            else
            begin
                x = $urandom_range(0, POS_MAX);
                y = $urandom_range(0, POS_MAX);
                send_rand(rand_tick(1'b1, x, y));

                // long holds can push the timer into saturation
                long_hold = ($urandom_range(0, 29) == 0);
                len   = long_hold ? 70 + $urandom_range(0, 10) : $urandom_range(0, 10);
                style = $urandom_range(0, 2);
                for (i = 0; i < len; i++)
                begin
                    case (style)
                        0:
                        begin
                            x = x + rand_signed(100);
                            y = y + rand_signed(8);
                        end
                        1:
                        begin
                            x = x + rand_signed(8);
                            y = y + rand_signed(60);
                        end
                        default:
                        begin
                            x = x + rand_signed(12);
                            y = y + rand_signed(12);
                        end
                    endcase
                    x = clamp_px(x);
                    y = clamp_px(y);
                    t = rand_tick(1'b1, x, y);
                    if (long_hold)
                        t.ms = MS_W'($urandom_range(900, 1000));
                    send_rand(t);
                end

                // release aimed at a click, a swipe, anywhere, or where the pointer is
                case ($urandom_range(0, 3))
                    0:
                    begin
                        rad = int'(gst_cfg.click_radius) / 2;
                        if (rad > 200)
                            rad = 200;
                        x = int'(gst_origin_x) + rand_signed(rad);
                        y = int'(gst_origin_y) + rand_signed(rad);
                    end
                    1:
                    begin
                        rad = int'(gst_cfg.swipe_limit) / 4;
                        x = int'(gst_origin_x) + rand_signed(rad);
                        y = int'(gst_origin_y) + int'(gst_cfg.swipe_limit)
                            + int'($urandom_range(1, 200));
                    end
                    2:
                    begin
                        x = $urandom_range(0, POS_MAX);
                        y = $urandom_range(0, POS_MAX);
                    end
                    default: ;
                endcase
                send_rand(rand_tick(1'b0, x, y));

                // up to two released frames between gestures
                repeat ($urandom_range(0, 2))
                    send_rand(rand_tick(1'b0, $urandom_range(0, POS_MAX),
                                        $urandom_range(0, POS_MAX)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, in-order compare against the predictor
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        gesture_result_t due;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (action <= 3'd6)
                action_seen[action]++;
            if (soft_drop)
                soft_seen++;
            if (gesture_results_due.size() == 0)
            begin
                $error("result transaction with nothing expected: action %0d soft_drop %0b",
                       action, soft_drop);
                fail_count++;
            end
            else
            begin
                due = gesture_results_due.pop_front();
                if (action !== due.action)
                begin
                    $error("action: expected %0d, got %0d", due.action, action);
                    fail_count++;
                end
                if (soft_drop !== due.soft_drop)
                begin
                    $error("soft_drop: expected %0b, got %0b", due.soft_drop, soft_drop);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $error("no transaction for %0d cycles, %0d results outstanding",
                       idle_cycles, gesture_results_due.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_t reg_plan[PLAN_LEN];
        int p;

        // every input known from time zero
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        button_down   = 1'b0;
        pos_x         = '0;
        pos_y         = '0;
        key_edges     = '0;
        soft_key_held = 1'b0;
        frame_ms      = '0;
        out_stall     = 1'b0;
        fail_count    = 0;
        ticks_sent    = 0;
        results_seen  = 0;
        settings_seen = 1;
        soft_seen     = 0;
        idle_cycles   = 0;
        foreach (action_seen[i])
            action_seen[i] = 0;
        send_idle_pct = 18;
        recv_idle_pct = 57;
        reset_gesture_model();

        // register settings per phase: moderate, both extremes, zero drag step,
        // and random picks
        reg_plan[0] = '{swipe_limit: 12'd150, click_radius: 12'd25, drag_step: 12'd30,
                        axis_ratio: 8'd20, hold_limit: 16'd500};
        reg_plan[1] = '{swipe_limit: 12'd0, click_radius: 12'd0, drag_step: 12'd1,
                        axis_ratio: 8'd0, hold_limit: 16'd0};
        reg_plan[2] = '{swipe_limit: 12'd4095, click_radius: 12'd4095, drag_step: 12'd4095,
                        axis_ratio: 8'd255, hold_limit: 16'd65535};
        reg_plan[3] = '{swipe_limit: 12'd60, click_radius: 12'd50, drag_step: 12'd0,
                        axis_ratio: 8'd16, hold_limit: 16'd1000};
        reg_plan[4] = '{swipe_limit: 12'($urandom_range(0, 600)),
                        click_radius: 12'($urandom_range(0, 300)),
                        drag_step: 12'($urandom_range(1, 200)),
                        axis_ratio: 8'($urandom_range(0, 255)),
                        hold_limit: 16'($urandom_range(0, 65535))};
        reg_plan[5] = '{swipe_limit: 12'd200, click_radius: 12'd30, drag_step: 12'd8,
                        axis_ratio: 8'd40, hold_limit: 16'd5000};
        reg_plan[6] = '{swipe_limit: 12'($urandom_range(0, 4095)),
                        click_radius: 12'($urandom_range(0, 4095)),
                        drag_step: 12'($urandom_range(1, 4095)),
                        axis_ratio: 8'($urandom_range(0, 255)),
                        hold_limit: 16'($urandom_range(0, 65535))};

        // directed rows at reset register values
        // key priority: idle, then each key in turn at the top of the chain, then the soft key
        add_row(0, 0,    0,    6'h00, 0, 0,    1, ACT_NONE,      0);
        add_row(0, 4095, 4095, 6'h3F, 0, 1000, 1, ACT_LEFT,      0);
        add_row(0, 0,    4095, 6'h3E, 0, 0,    1, ACT_RIGHT,     0);
        add_row(0, 4095, 0,    6'h3C, 0, 7,    1, ACT_ROTATE,    0);
        add_row(0, 0,    0,    6'h38, 0, 0,    1, ACT_START,     0);
        add_row(0, 0,    0,    6'h30, 0, 0,    1, ACT_PAUSE,     0);
        add_row(0, 0,    0,    6'h20, 0, 0,    1, ACT_HARD_DROP, 0);
        add_row(0, 4095, 0,    6'h00, 1, 0,    1, ACT_NONE,      1);
        // press and release close by: click
        add_row(1, 100,  100,  6'h00, 0, 0,    1, ACT_NONE,      0);
        add_row(0, 105,  105,  6'h00, 0, 0,    1, ACT_ROTATE,    0);
        // press and pull straight down: swipe wins over a key
        add_row(1, 2000, 0,    6'h00, 0, 0,    1, ACT_NONE,      0);
        add_row(0, 2000, 4095, 6'h01, 0, 0,    1, ACT_HARD_DROP, 0);
        // horizontal drag right across the screen, hold timer running
        add_row(1, 0,    0,    6'h00, 0, 1000, 0, ACT_NONE,      0);
        add_row(1, 4095, 0,    6'h00, 0, 1000, 0, ACT_NONE,      0);
        add_row(1, 4095, 5,    6'h02, 0, 1000, 0, ACT_NONE,      0);
        add_row(0, 4095, 0,    6'h00, 0, 0,    0, ACT_NONE,      0);
        // drag left from the far corner
        add_row(1, 4095, 4095, 6'h00, 0, 0,    0, ACT_NONE,      0);
        add_row(1, 0,    4095, 6'h00, 1, 0,    0, ACT_NONE,      0);
        add_row(1, 0,    4095, 6'h00, 0, 1000, 0, ACT_NONE,      0);
        add_row(0, 0,    0,    6'h00, 0, 0,    0, ACT_NONE,      0);
        // vertical hold just past the time limit, release short of a swipe
        add_row(1, 500,  500,  6'h00, 0, 300,  0, ACT_NONE,      0);
        add_row(1, 500,  520,  6'h00, 0, 1,    0, ACT_NONE,      0);
        add_row(0, 500,  600,  6'h00, 0, 0,    0, ACT_NONE,      0);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_rows[i])
            send_tick(stim_rows[i].tick, stim_rows[i].typed, stim_rows[i].want);

        for (p = 0; p < PLAN_LEN; p++)
        begin
            // sender light / receiver heavy, then swapped, then full rate
            if (p < 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 57;
            end
            else if (p < 5)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            apply_setting(reg_plan[p]);
            run_gestures(PHASE_TICKS / 2);
            // sender holds off until the pipe is empty mid-phase
            wait_drained();
            run_gestures(PHASE_TICKS - PHASE_TICKS / 2);
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d ticks over %0d register settings, %0d results checked",
                 ticks_sent, settings_seen, results_seen);
        $display("actions: left %0d right %0d rotate %0d hard %0d start %0d pause %0d, soft %0d",
                 action_seen[ACT_LEFT], action_seen[ACT_RIGHT], action_seen[ACT_ROTATE],
                 action_seen[ACT_HARD_DROP], action_seen[ACT_START], action_seen[ACT_PAUSE],
                 soft_seen);
        if (fail_count == 0 && gesture_results_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ pointer_gesture_classifier.f @@
+incdir+rtl
rtl/pgc_pkg.sv
rtl/pgc_track.sv
rtl/pgc_decide.sv
rtl/pointer_gesture_classifier.sv
bench/pointer_gesture_classifier_tb.sv
